[rtl/tkcs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkcs_pkg: shared types and constants of the top-k count selector
// Entry, request, result, store write and compare result types used across the modules.
// ----------------------------------------------------------------------------
package tkcs_pkg;

  localparam int K_MAX      = 16;
  localparam int KEY_BITS   = 32;
  localparam int COUNT_BITS = 32;
  localparam int K_W        = 5;
  localparam int IDX_W      = $clog2(K_MAX);
  localparam int FILL_W     = $clog2(K_MAX + 1);

  localparam logic ACT_OFFER = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;

  typedef struct packed {
    logic                  action;
    logic [KEY_BITS-1:0]   key_tag;
    logic [COUNT_BITS-1:0] item_count;
  } req_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]   out_key;
    logic [COUNT_BITS-1:0] out_count;
    logic                  out_valid;
    logic                  out_last;
  } res_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]   key;
    logic [COUNT_BITS-1:0] count;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } wr_t;

  typedef struct packed {
    logic gt;
    logic lt;
  } cmp_t;

endpackage

[rtl/tkcs_cmp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkcs_cmp: shared count comparator
// Compares a held count against the count of the pending request.
// ----------------------------------------------------------------------------
module tkcs_cmp (
  input  logic [tkcs_pkg::COUNT_BITS-1:0] held_i,
  input  logic [tkcs_pkg::COUNT_BITS-1:0] new_i,
  output tkcs_pkg::cmp_t                  cmp_o
);

  assign cmp_o.gt = (held_i > new_i);
  assign cmp_o.lt = (held_i < new_i);

endmodule

[rtl/tkcs_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkcs_store: sorted entry store
// Register file of held entries with one write port and one read port.
// ----------------------------------------------------------------------------
module tkcs_store (
  input  logic                         clk_i,
  input  tkcs_pkg::wr_t                wr_i,
  input  logic [tkcs_pkg::IDX_W-1:0]   rd_idx_i,
  output tkcs_pkg::entry_t             rd_o
);

  tkcs_pkg::entry_t mem_q [tkcs_pkg::K_MAX];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  assign rd_o = mem_q[rd_idx_i];

endmodule

[rtl/top_k_count_selector.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_k_count_selector: keeps the k held entries with the largest counts
// Offers walk the sorted store one entry per cycle through one shared comparator.
// An ignored offer (k of zero) keeps the block idle; a rejected one passes the
// check state; a stored one walks in the insert or replace state, busy meanwhile.
// A drain strobes one registered result per cycle, smallest count first; an empty
// drain strobes one invalid result marked last. Results cannot be stalled.
// Reset empties the store and sets k_q to 16.
// ----------------------------------------------------------------------------
module top_k_count_selector (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  tkcs_pkg::req_t             req_i,
  output logic                       strobe_o,
  output tkcs_pkg::res_t             res_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [tkcs_pkg::K_W-1:0]   cfg_data_i
);

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_CHECK   = 5'b00010,
    ST_INSERT  = 5'b00100,
    ST_REPLACE = 5'b01000,
    ST_DRAIN   = 5'b10000
  } state_e;

  localparam logic [tkcs_pkg::K_W-1:0]    KMaxK  = tkcs_pkg::K_W'(tkcs_pkg::K_MAX);
  localparam logic [tkcs_pkg::FILL_W-1:0] FillOne = tkcs_pkg::FILL_W'(1);

  state_e                          state_q, state_d;
  logic [tkcs_pkg::K_W-1:0]        k_q;
  logic [tkcs_pkg::FILL_W-1:0]     fill_q, fill_d;
  logic [tkcs_pkg::FILL_W-1:0]     pos_q, pos_d;
  tkcs_pkg::req_t                  pend_q, pend_d;
  logic                            strobe_q, strobe_d;
  tkcs_pkg::res_t                  res_q, res_d;

  logic [tkcs_pkg::K_W-1:0]        k_eff;
  logic [tkcs_pkg::FILL_W-1:0]     k_fill;
  logic [tkcs_pkg::FILL_W-1:0]     pos_dec;
  logic [tkcs_pkg::IDX_W-1:0]      rd_idx;
  tkcs_pkg::entry_t                rd_entry;
  tkcs_pkg::wr_t                   wr;
  tkcs_pkg::cmp_t                  cmp;
  tkcs_pkg::entry_t                new_entry;
  logic                            accept;

  assign accept      = start && !busy;
  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign strobe_o    = strobe_q;
  assign res_o       = res_q;

  assign k_eff  = (k_q > KMaxK) ? KMaxK : k_q;
  assign k_fill = tkcs_pkg::FILL_W'(k_eff);
  assign pos_dec = pos_q - FillOne;

  assign new_entry.key   = pend_q.key_tag;
  assign new_entry.count = pend_q.item_count;

  tkcs_store u_store (
    .clk_i    (clk_i),
    .wr_i     (wr),
    .rd_idx_i (rd_idx),
    .rd_o     (rd_entry)
  );

  tkcs_cmp u_cmp (
    .held_i (rd_entry.count),
    .new_i  (pend_q.item_count),
    .cmp_o  (cmp)
  );

  always_comb begin
    state_d  = state_q;
    fill_d   = fill_q;
    pos_d    = pos_q;
    pend_d   = pend_q;
    strobe_d = 1'b0;
    res_d    = res_q;
    wr       = '0;
    rd_idx   = pos_q[tkcs_pkg::IDX_W-1:0];

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          pend_d = req_i;
          if (req_i.action == tkcs_pkg::ACT_DRAIN) begin
            pos_d   = '0;
            state_d = ST_DRAIN;
          end else if (fill_q < k_fill) begin
            pos_d   = fill_q;
            state_d = ST_INSERT;
          end else if (k_eff != '0 && fill_q != '0) begin
            state_d = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        // The smallest entry sits at the bottom of the sorted store.
        rd_idx = '0;
        if (cmp.lt) begin
          pos_d   = FillOne;
          state_d = ST_REPLACE;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_INSERT: begin
        rd_idx  = pos_dec[tkcs_pkg::IDX_W-1:0];
        wr.en   = 1'b1;
        wr.addr = pos_q[tkcs_pkg::IDX_W-1:0];
        if (pos_q != '0 && cmp.gt) begin
          wr.data = rd_entry;
          pos_d   = pos_dec;
        end else begin
          wr.data = new_entry;
          fill_d  = fill_q + FillOne;
          state_d = ST_IDLE;
        end
      end
      ST_REPLACE: begin
        // Entries not above the new count move down over the evicted minimum.
        rd_idx  = pos_q[tkcs_pkg::IDX_W-1:0];
        wr.en   = 1'b1;
        wr.addr = pos_dec[tkcs_pkg::IDX_W-1:0];
        if (pos_q < fill_q && !cmp.gt) begin
          wr.data = rd_entry;
          pos_d   = pos_q + FillOne;
        end else begin
          wr.data = new_entry;
          state_d = ST_IDLE;
        end
      end
      ST_DRAIN: begin
        strobe_d = 1'b1;
        if (fill_q == '0) begin
          res_d   = '{out_key: '0, out_count: '0, out_valid: 1'b0, out_last: 1'b1};
          state_d = ST_IDLE;
        end else begin
          res_d.out_key   = rd_entry.key;
          res_d.out_count = rd_entry.count;
          res_d.out_valid = 1'b1;
          res_d.out_last  = (pos_q + FillOne == fill_q);
          if (pos_q + FillOne == fill_q) begin
            fill_d  = '0;
            state_d = ST_IDLE;
          end else begin
            pos_d = pos_q + FillOne;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      fill_q   <= '0;
      pos_q    <= '0;
      strobe_q <= 1'b0;
      k_q      <= KMaxK;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      pos_q    <= pos_d;
      strobe_q <= strobe_d;
      if (cfg_valid_i && cfg_ready_o) begin
        k_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    res_q  <= res_d;
  end

endmodule

[dv/top_k_count_selector_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_k_count_selector_tb: self-checking testbench for the top-k count selector
// A queue of offer and drain requests feeds a clocked driver with random idle
// bursts. A behavioral top-k store predicts every drained entry, and a clocked
// monitor compares each strobed result with the oldest prediction. The run
// covers directed corner cases and random phases at several k settings.
// ----------------------------------------------------------------------------
module top_k_count_selector_tb;

  localparam int RUN_LIMIT   = 200000;
  localparam int SETTLE_WAIT = tkcs_pkg::K_MAX + 4;

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     start       = 1'b0;
  logic                     busy;
  tkcs_pkg::req_t           req_i       = '0;
  logic                     strobe_o;
  tkcs_pkg::res_t           res_o;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [tkcs_pkg::K_W-1:0] cfg_data_i  = '0;

  tkcs_pkg::req_t   stimulus_q[$];
  tkcs_pkg::res_t   drained_q[$];
  tkcs_pkg::entry_t kept[tkcs_pkg::K_MAX];
  int     kept_fill     = 0;
  int     k_setting     = 16;
  int     idle_left     = 0;
  bit     idle_on       = 1'b1;
  int     mismatches    = 0;
  int     cycles        = 0;
  int     offers_sent   = 0;
  int     drains_sent   = 0;
  int     results_seen  = 0;
  int     k_writes      = 0;
  tkcs_pkg::res_t   want_res;

  top_k_count_selector u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .strobe_o    (strobe_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Behavioral top-k store: ascending by count, older entry first among ties.
  task automatic update_top_k(input tkcs_pkg::req_t r);
    int k_eff;
    int pos;
    tkcs_pkg::res_t item;
    k_eff = (k_setting > tkcs_pkg::K_MAX) ? tkcs_pkg::K_MAX : k_setting;
    if (r.action == tkcs_pkg::ACT_OFFER) begin
      offers_sent++;
      if (kept_fill < k_eff || (k_eff > 0 && kept_fill > 0 && kept[0].count < r.item_count))
      begin
        if (kept_fill >= k_eff) begin
          for (int i = 1; i < kept_fill; i++) kept[i-1] = kept[i];
          kept_fill--;
        end
        pos = kept_fill;
        while (pos > 0 && kept[pos-1].count > r.item_count) begin
          kept[pos] = kept[pos-1];
          pos--;
        end
        kept[pos] = '{key: r.key_tag, count: r.item_count};
        kept_fill++;
      end
    end else begin
      drains_sent++;
      if (kept_fill == 0) begin
        item = '{out_key: '0, out_count: '0, out_valid: 1'b0, out_last: 1'b1};
        drained_q.insert(drained_q.size(), item);
      end else begin
        for (int i = 0; i < kept_fill; i++) begin
          item = '{out_key: kept[i].key, out_count: kept[i].count,
                   out_valid: 1'b1, out_last: (i == kept_fill - 1)};
          drained_q.insert(drained_q.size(), item);
        end
      end
      kept_fill = 0;
    end
  endtask

  // Driver: holds a request until accepted, with random idle bursts between requests.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start     <= 1'b0;
      idle_left <= 0;
    end else begin
      if (start && !busy) update_top_k(req_i);
      if (start && busy) begin
        start <= 1'b1;
      end else if (idle_left > 0) begin
        idle_left <= idle_left - 1;
        start     <= 1'b0;
      end else if (idle_on && stimulus_q.size() != 0 && $urandom_range(0, 7) == 0) begin
        idle_left <= $urandom_range(0, 12);
        start     <= 1'b0;
      end else if (stimulus_q.size() != 0) begin
        req_i <= stimulus_q.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic check_field(input string what, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      mismatches++;
      $display("t=%0t: %s expected %h, actual %h", $time, what, want_v, got_v);
    end
  endtask

  // Monitor: every strobed result is accepted at the edge that ends its cycle.
  always @(posedge clk_i) begin
    if (rst_ni && strobe_o) begin
      results_seen++;
      if (drained_q.size() == 0) begin
        mismatches++;
        $display("t=%0t: expected no result, actual key %h count %h valid %b last %b",
                 $time, res_o.out_key, res_o.out_count, res_o.out_valid, res_o.out_last);
      end else begin
        want_res = drained_q.pop_front();
        check_field("out_key", want_res.out_key, res_o.out_key);
        check_field("out_count", want_res.out_count, res_o.out_count);
        check_field("out_valid", 32'(want_res.out_valid), 32'(res_o.out_valid));
        check_field("out_last", 32'(want_res.out_last), 32'(res_o.out_last));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > RUN_LIMIT) begin
      $display("t=%0t: run limit of %0d cycles reached", $time, RUN_LIMIT);
      $display("top_k_count_selector: mismatch");
      $finish;
    end
  end

  task automatic offer(input logic [31:0] key, input logic [31:0] cnt);
    tkcs_pkg::req_t r;
    r = '{action: tkcs_pkg::ACT_OFFER, key_tag: key, item_count: cnt};
    stimulus_q.insert(stimulus_q.size(), r);
  endtask

  task automatic drain();
    tkcs_pkg::req_t r;
    r = '{action: tkcs_pkg::ACT_DRAIN, key_tag: $urandom, item_count: $urandom};
    stimulus_q.insert(stimulus_q.size(), r);
  endtask

  // Offers give no result, so after the last drain the block may still be busy.
  task automatic settle();
    while (stimulus_q.size() != 0 || start || drained_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_WAIT) @(negedge clk_i);
  endtask

  task automatic write_k(input int value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value[tkcs_pkg::K_W-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    k_setting = value;
    k_writes++;
    @(negedge clk_i);
  endtask

  initial begin
    int k_plan[9];
    int n_items;
    logic [31:0] cnt;
    k_plan = '{31, 1, 16, 0, 17, -1, 4, -1, 16};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Empty drain, field extremes and a three-way tie at the reset setting.
    drain();
    offer(32'h0000_0000, 32'h0000_0000);
    offer(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    offer(32'h0000_0001, 32'd5);
    offer(32'h0000_0002, 32'd5);
    offer(32'h0000_0003, 32'd5);
    drain();
    settle();

    // With two slots: an equal count is rejected, a larger one evicts the older tie.
    write_k(2);
    offer(32'hA0, 32'd10);
    offer(32'hA1, 32'd10);
    offer(32'hA2, 32'd10);
    offer(32'hA3, 32'd11);
    offer(32'hA4, 32'd3);
    drain();
    settle();

    // Nothing is kept at zero.
    write_k(0);
    offer(32'hB0, 32'd99);
    drain();
    settle();

    // Lowering k below the fill level keeps the held entries.
    write_k(16);
    for (int i = 0; i < 6; i++) offer(32'hC0 + i, 32'd20 + i);
    settle();
    write_k(3);
    offer(32'hD0, 32'd100);
    offer(32'hD1, 32'd1);
    drain();
    settle();

    for (int ph = 0; ph < 9; ph++) begin
      write_k(k_plan[ph] < 0 ? $urandom_range(0, 31) : k_plan[ph]);
      idle_on = (ph != 8) && ($urandom_range(0, 3) != 0);
      n_items = (k_plan[ph] == 0) ? 10 : 30;
      for (int i = 0; i < n_items; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          drain();
        end else begin
          case ($urandom_range(0, 3))
            0:       cnt = $urandom_range(0, 7);
            1:       cnt = 32'hFFFF_FFF8 | $urandom_range(0, 7);
            2:       cnt = $urandom_range(0, 255);
            default: cnt = $urandom;
          endcase
          offer($urandom, cnt);
        end
      end
      // Phase 5 leaves its entries held so that phase 6 can start above its k.
      if (ph != 5 && $urandom_range(0, 2) != 0) drain();
      settle();
    end
    drain();
    settle();

    if (drained_q.size() != 0) begin
      mismatches++;
      $display("t=%0t: %0d expected results never arrived", $time, drained_q.size());
    end
    $display("Sent %0d offers and %0d drains across %0d k settings.",
             offers_sent, drains_sent, k_writes);
    $display("Checked %0d drained results; %0d field mismatches.", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("top_k_count_selector: match");
    end else begin
      $display("top_k_count_selector: mismatch");
    end
    $finish;
  end

endmodule

[top_k_count_selector.f]
rtl/tkcs_pkg.sv
rtl/tkcs_cmp.sv
rtl/tkcs_store.sv
rtl/top_k_count_selector.sv
dv/top_k_count_selector_tb.sv
